// File: src/fmmp_pkg.sv
package fmmp_pkg;

  localparam int IDX_W  = 32;
  localparam int MOD_W  = 24;
  localparam int BCNT_W = $clog2(IDX_W);
  localparam int MCNT_W = $clog2(MOD_W);

  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(10000007);

  typedef logic [MOD_W-1:0] res_t;

  // 2x2 matrix [[a, b], [c, d]]
  typedef struct packed {
    res_t a;
    res_t b;
    res_t c;
    res_t d;
  } mat_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] expo;
  } eng_req_t;

  typedef struct packed {
    logic idle;
    logic done;
    res_t value;
  } eng_sts_t;

  // (a + b) mod m, both operands already below m
  function automatic res_t mod_add(res_t a, res_t b, res_t m);
    logic [MOD_W:0]   s;
    logic [MOD_W+1:0] d;
    s = {1'b0, a} + {1'b0, b};
    d = {1'b0, s} - {2'b00, m};
    if (d[MOD_W+1]) begin
      return s[MOD_W-1:0];
    end
    return d[MOD_W-1:0];
  endfunction

endpackage

// File: src/fibonacci_mod_matrix_power.sv
// Fibonacci modulo m by 2x2 matrix exponentiation. Each transfer on the
// in_ channel carries an index n; one transfer on the out_ channel returns
// F(n) mod m, where m is the modulus register (reset 10000007, written
// through the cfg_ port while the block is idle). Index 0, and any modulus
// below 2, answer 0 without the engine. Otherwise [[1,1],[1,0]] is raised
// to n-1 by square-and-multiply, exponent MSB first, with leading zero bits
// skipped. From the first set bit on, every exponent bit costs one matrix
// squaring done by four bit-serial modular multiply-add lanes, one
// multiplier bit per cycle, plus a multiply by the base when the bit is
// set. One item is in work at a time; a new index is taken as soon as the
// previous result has moved into the output register, even while that
// result still waits for out_ready, unless a modulus write is waiting.
module fibonacci_mod_matrix_power import fmmp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [MOD_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [IDX_W-1:0] in_index,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [MOD_W-1:0] out_fib_value
);

  res_t     mod_r, mod_nxt;
  logic     busy_r, busy_nxt;      // item accepted, result not yet in output reg
  logic     pend_r, pend_nxt;      // result ready, waiting for output reg
  res_t     pend_val_r, pend_val_nxt;
  logic     out_valid_r, out_valid_nxt;
  res_t     out_val_r, out_val_nxt;
  logic     in_fire;
  logic     special;
  eng_req_t req;
  eng_sts_t sts;

  // a waiting modulus write goes first, so no index sees a mixed modulus
  assign in_ready  = !busy_r && !cfg_valid;
  // modulus only changes with nothing in flight
  assign cfg_ready = !busy_r && !out_valid_r;
  assign in_fire   = in_valid && in_ready;

  // index zero or modulus 0/1 answer 0 without the engine
  assign special = (in_index == '0) || (mod_r[MOD_W-1:1] == '0);

  assign req.start = in_fire && !special;
  assign req.expo  = in_index - IDX_W'(1);

  fmmp_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .m     (mod_r),
    .sts   (sts)
  );

  always_comb begin
    mod_nxt       = mod_r;
    busy_nxt      = busy_r;
    pend_nxt      = pend_r;
    pend_val_nxt  = pend_val_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;

    if (cfg_valid && cfg_ready) begin
      mod_nxt = cfg_data;
    end

    if (in_fire) begin
      busy_nxt = 1'b1;
      if (special) begin
        pend_nxt     = 1'b1;
        pend_val_nxt = '0;
      end
    end

    if (sts.done) begin
      pend_nxt     = 1'b1;
      pend_val_nxt = sts.value;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (pend_r && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = pend_val_r;
      pend_nxt      = 1'b0;
      busy_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r       <= MOD_RESET;
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mod_r       <= mod_nxt;
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_val_r <= pend_val_nxt;
    out_val_r  <= out_val_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_fib_value = out_val_r;

  // engine only runs on behalf of an accepted item
  a_idle_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> sts.idle)
    else $error("engine active with no item in flight");

  // engine finishes only while its item still owns the result slot
  a_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (busy_r && !pend_r))
    else $error("engine done without a pending item");

  // a regular index starts the engine on the following cycle
  a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !special) |=> !sts.idle)
    else $error("accepted index did not start the engine");

  // every delivered value is reduced
  a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_val_r < mod_r) || (mod_r[MOD_W-1:1] == '0)))
    else $error("result not reduced modulo the modulus");

endmodule

// File: src/fmmp_lane.sv
// Bit-serial modular sum of two products: x0*y0 + x1*y1 mod m.
// Multiplier bits arrive MSB first on b0/b1, one per step.
module fmmp_lane import fmmp_pkg::*; (
  input  logic clk,
  input  res_t m,
  input  res_t x0,
  input  res_t x1,
  input  logic load,
  input  logic step,
  input  logic b0,
  input  logic b1,
  output res_t r,
  output res_t s01
);

  localparam int SW = MOD_W + 3;

  res_t           r_r, r_nxt;
  res_t           s01_r, s01_nxt;
  res_t           v;
  logic [SW-1:0]  t, d1, d2;

  always_comb begin
    case ({b0, b1})
      2'b11:   v = s01_r;
      2'b10:   v = x0;
      2'b01:   v = x1;
      default: v = '0;
    endcase
  end

  // 2r + v < 3m: at most two subtractions of m
  assign t  = {2'b00, r_r, 1'b0} + {3'b000, v};
  assign d1 = t - {3'b000, m};
  assign d2 = t - {2'b00, m, 1'b0};

  always_comb begin
    r_nxt   = r_r;
    s01_nxt = s01_r;
    if (load) begin
      r_nxt   = '0;
      s01_nxt = mod_add(x0, x1, m);
    end else if (step) begin
      if (!d2[SW-1]) begin
        r_nxt = d2[MOD_W-1:0];
      end else if (!d1[SW-1]) begin
        r_nxt = d1[MOD_W-1:0];
      end else begin
        r_nxt = t[MOD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r   <= r_nxt;
    s01_r <= s01_nxt;
  end

  assign r   = r_r;
  assign s01 = s01_r;

endmodule

// File: src/fmmp_engine.sv
// Square-and-multiply sequencer over the exponent, MSB first.
// Squaring uses four bit-serial lanes; multiply by [[1,1],[1,0]]
// reduces to two modular adds taken from the lanes' pre-sum.
module fmmp_engine import fmmp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  eng_req_t req,
  input  res_t     m,
  output eng_sts_t sts
);

  typedef enum logic [7:0] {
    E_IDLE      = 8'b0000_0001,
    E_BIT       = 8'b0000_0010,
    E_SQ_LOAD   = 8'b0000_0100,
    E_SQ_RUN    = 8'b0000_1000,
    E_SQ_COMMIT = 8'b0001_0000,
    E_MB_LOAD   = 8'b0010_0000,
    E_MB_COMMIT = 8'b0100_0000,
    E_DONE      = 8'b1000_0000
  } eng_state_t;

  localparam mat_t IDENT = '{a: res_t'(1), b: '0, c: '0, d: res_t'(1)};

  eng_state_t       state_r, state_nxt;
  mat_t             acc_r, acc_nxt;
  mat_t             sh_r, sh_nxt;
  logic [IDX_W-1:0] e_r, e_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [MCNT_W-1:0] mcnt_r, mcnt_nxt;
  logic             started_r, started_nxt;
  logic             adv;
  logic             lane_load, lane_step;
  res_t             lr_a, lr_b, lr_c, lr_d;
  res_t             s01_a, s01_c;

  assign lane_load = (state_r == E_SQ_LOAD) || (state_r == E_MB_LOAD);
  assign lane_step = (state_r == E_SQ_RUN);

  fmmp_lane u_lane_a (
    .clk(clk), .m(m), .x0(acc_r.a), .x1(acc_r.b), .load(lane_load), .step(lane_step),
    .b0(sh_r.a[MOD_W-1]), .b1(sh_r.c[MOD_W-1]), .r(lr_a), .s01(s01_a)
  );
  fmmp_lane u_lane_b (
    .clk(clk), .m(m), .x0(acc_r.a), .x1(acc_r.b), .load(lane_load), .step(lane_step),
    .b0(sh_r.b[MOD_W-1]), .b1(sh_r.d[MOD_W-1]), .r(lr_b), .s01()
  );
  fmmp_lane u_lane_c (
    .clk(clk), .m(m), .x0(acc_r.c), .x1(acc_r.d), .load(lane_load), .step(lane_step),
    .b0(sh_r.a[MOD_W-1]), .b1(sh_r.c[MOD_W-1]), .r(lr_c), .s01(s01_c)
  );
  fmmp_lane u_lane_d (
    .clk(clk), .m(m), .x0(acc_r.c), .x1(acc_r.d), .load(lane_load), .step(lane_step),
    .b0(sh_r.b[MOD_W-1]), .b1(sh_r.d[MOD_W-1]), .r(lr_d), .s01()
  );

  always_comb begin
    state_nxt   = state_r;
    acc_nxt     = acc_r;
    sh_nxt      = sh_r;
    e_nxt       = e_r;
    bcnt_nxt    = bcnt_r;
    mcnt_nxt    = mcnt_r;
    started_nxt = started_r;
    adv         = 1'b0;
    case (state_r)
      E_IDLE: begin
        if (req.start) begin
          acc_nxt     = IDENT;
          e_nxt       = req.expo;
          bcnt_nxt    = BCNT_W'(IDX_W - 1);
          started_nxt = 1'b0;
          state_nxt   = E_BIT;
        end
      end
      E_BIT: begin
        // leading zero bits only square the identity: skip them
        if (started_r || e_r[IDX_W-1]) begin
          started_nxt = 1'b1;
          state_nxt   = E_SQ_LOAD;
        end else begin
          adv = 1'b1;
        end
      end
      E_SQ_LOAD: begin
        sh_nxt    = acc_r;
        mcnt_nxt  = MCNT_W'(MOD_W - 1);
        state_nxt = E_SQ_RUN;
      end
      E_SQ_RUN: begin
        sh_nxt.a = {sh_r.a[MOD_W-2:0], 1'b0};
        sh_nxt.b = {sh_r.b[MOD_W-2:0], 1'b0};
        sh_nxt.c = {sh_r.c[MOD_W-2:0], 1'b0};
        sh_nxt.d = {sh_r.d[MOD_W-2:0], 1'b0};
        if (mcnt_r == '0) begin
          state_nxt = E_SQ_COMMIT;
        end else begin
          mcnt_nxt = mcnt_r - MCNT_W'(1);
        end
      end
      E_SQ_COMMIT: begin
        acc_nxt = '{a: lr_a, b: lr_b, c: lr_c, d: lr_d};
        if (e_r[IDX_W-1]) begin
          state_nxt = E_MB_LOAD;
        end else begin
          adv = 1'b1;
        end
      end
      E_MB_LOAD: begin
        state_nxt = E_MB_COMMIT;
      end
      E_MB_COMMIT: begin
        // [[a,b],[c,d]] * [[1,1],[1,0]] = [[a+b, a], [c+d, c]]
        acc_nxt = '{a: s01_a, b: acc_r.a, c: s01_c, d: acc_r.c};
        adv     = 1'b1;
      end
      E_DONE: begin
        state_nxt = E_IDLE;
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
    if (adv) begin
      e_nxt = {e_r[IDX_W-2:0], 1'b0};
      if (bcnt_r == '0) begin
        state_nxt = E_DONE;
      end else begin
        bcnt_nxt  = bcnt_r - BCNT_W'(1);
        state_nxt = E_BIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= E_IDLE;
      bcnt_r    <= '0;
      mcnt_r    <= '0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      bcnt_r    <= bcnt_nxt;
      mcnt_r    <= mcnt_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    e_r   <= e_nxt;
  end

  assign sts.idle  = (state_r == E_IDLE);
  assign sts.done  = (state_r == E_DONE);
  assign sts.value = acc_r.a;

endmodule

// File: tb/sv/fibonacci_mod_matrix_power_tb.sv
module fibonacci_mod_matrix_power_tb;
  import fmmp_pkg::*;

  // The slowest index has a full 32-bit exponent; this limit leaves several
  // times the slowest run of all items plus stalls.
  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  // Idle time allowed after the last result, in case a stray one shows up.
  localparam int unsigned TAIL_CYCLES = 1000;

  // One expected answer, kept with its index so a mismatch can name it.
  typedef struct {
    logic [IDX_W-1:0] index;
    res_t             value;
  } fib_expect_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [MOD_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [IDX_W-1:0] in_index = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [MOD_W-1:0] out_fib_value;

  // Indexes waiting to go out on the in_ channel, and answers still owed.
  logic [IDX_W-1:0] pending_index_q[$];
  fib_expect_t      fib_expected_q[$];

  // Shadow copy of the modulus register; only changes while the block is idle.
  res_t             modulus_shadow = MOD_RESET;

  int unsigned      issued_count = 0;
  int unsigned      accepted_count = 0;
  int unsigned      error_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  fib_expect_t      oldest_fib;

  // Edge cases for the default modulus: tiny indexes, powers of two around
  // the top bit, alternating bit patterns and the largest index.
  logic [IDX_W-1:0] directed_idx [22] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd10, 32'd20, 32'd31,
    32'd32, 32'd33, 32'd64, 32'd93, 32'd94, 32'd1000,
    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001,
    32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF
  };

  fibonacci_mod_matrix_power dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_index      (in_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_fib_value (out_fib_value)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Fibonacci predictor: [[1,1],[1,0]]^(n-1) by square-and-multiply,
  // exponent MSB first, every product and sum reduced mod m. F(n) is the
  // top-left entry of the power.
  // ---------------------------------------------------------------------

  // (x0*y0 + x1*y1) mod m, one entry of a 2x2 product; 48-bit products fit.
  function automatic res_t mat_entry(res_t x0, res_t y0, res_t x1, res_t y1, res_t m);
    longint unsigned mm;
    mm = 64'(m);
    return res_t'(((64'(x0) * 64'(y0)) % mm + (64'(x1) * 64'(y1)) % mm) % mm);
  endfunction

  function automatic mat_t mat_product(mat_t x, mat_t y, res_t m);
    mat_t p;
    p.a = mat_entry(x.a, y.a, x.b, y.c, m);
    p.b = mat_entry(x.a, y.b, x.b, y.d, m);
    p.c = mat_entry(x.c, y.a, x.d, y.c, m);
    p.d = mat_entry(x.c, y.b, x.d, y.d, m);
    return p;
  endfunction

  function automatic res_t fib_mod(logic [IDX_W-1:0] n, res_t m);
    mat_t             step_m;
    mat_t             power;
    logic [IDX_W-1:0] e;
    // Modulus zero has no meaning: block answers 0. Index zero is F(0) = 0.
    if (m == '0 || n == '0) begin
      return '0;
    end
    step_m.a = 1; step_m.b = 1; step_m.c = 1; step_m.d = 0;
    power.a  = 1; power.b  = 0; power.c  = 0; power.d  = 1;
    e = n - 1'b1;
    for (int bit_pos = IDX_W - 1; bit_pos >= 0; bit_pos--) begin
      power = mat_product(power, power, m);
      if (e[bit_pos]) begin
        power = mat_product(power, step_m, m);
      end
    end
    // Final reduction; every entry is already below m after the products.
    return res_t'(64'(power.a) % 64'(m));
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: in_ channel. The slot is free when nothing is held or the held
  // item transfers at this edge; only then may a new index (or a gap) be
  // chosen. The expected answer is computed at the transfer itself, with
  // the modulus that is in force then.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        fib_expected_q.push_back('{index: in_index,
                                   value: fib_mod(in_index, modulus_shadow)});
        accepted_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_index_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_index <= pending_index_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: out_ channel. Each result transfer is checked against the
  // oldest outstanding answer; out_ready is redrawn every cycle.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (fib_expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing outstanding", out_fib_value));
        end else begin
          oldest_fib = fib_expected_q.pop_front();
          if (out_fib_value !== oldest_fib.value) begin
            report_mismatch($sformatf("index %0d modulus %0d: fib_value %0d, want %0d",
                                      oldest_fib.index, modulus_shadow,
                                      out_fib_value, oldest_fib.value));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Mostly short exponents keep the run length sane; about a fifth use the
  // full 32 bits so every index bit toggles and the long path is covered.
  function automatic logic [IDX_W-1:0] rand_index();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) begin
      return IDX_W'($urandom_range(3));
    end else if (sel < 50) begin
      return IDX_W'($urandom_range(255));
    end else if (sel < 78) begin
      return IDX_W'($urandom_range(4095));
    end
    return IDX_W'($urandom);
  endfunction

  task automatic queue_index(logic [IDX_W-1:0] idx);
    pending_index_q.push_back(idx);
    issued_count++;
  endtask

  // Every queued index transferred and every answer received. Each index
  // gives exactly one result, so the block is idle once this returns.
  task automatic wait_drained();
    while (accepted_count != issued_count || fib_expected_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Modulus write on the cfg_ channel; the shadow follows on the transfer.
  task automatic write_modulus(res_t value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!(cfg_valid && cfg_ready));
    modulus_shadow = value;
    cfg_valid <= 1'b0;
  endtask

  // One phase: optional modulus write, idling mix, a few fixed corner
  // indexes, then random ones, then wait for all answers.
  task automatic run_phase(bit do_write, res_t modulus, int unsigned send_pct,
                           int unsigned recv_pct, int unsigned count);
    if (do_write) begin
      write_modulus(modulus);
    end
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_index('0);
    queue_index(IDX_W'(1));
    queue_index(IDX_W'(2));
    queue_index('1);
    for (int i = 0; i < count; i++) begin
      queue_index(rand_index());
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset modulus untouched, directed corners first, no idling.
    foreach (directed_idx[i]) begin
      queue_index(directed_idx[i]);
    end
    run_phase(1'b0, MOD_RESET, 0, 0, 150);

    // Largest and smallest meaningful moduli.
    run_phase(1'b1, res_t'(24'hFF_FFFF), 46, 0, 250);
    run_phase(1'b1, res_t'(2), 0, 46, 200);
    // Degenerate moduli: one reduces everything to 0, zero answers 0.
    run_phase(1'b1, res_t'(1), 23, 23, 40);
    run_phase(1'b1, res_t'(0), 0, 0, 40);
    // Arbitrary full-range modulus, then the reset value written back.
    run_phase(1'b1, res_t'($urandom_range(24'hFF_FFFF, 2)), 23, 23, 250);
    run_phase(1'b1, MOD_RESET, 46, 0, 250);
    // Small modulus, where wraparound happens on nearly every add.
    run_phase(1'b1, res_t'($urandom_range(1000, 3)), 0, 46, 250);
    run_phase(1'b1, res_t'($urandom_range(24'hFF_FFFF, 2)), 0, 0, 250);

    // Quiet tail: any late or extra result still gets flagged.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && fib_expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: fibonacci_mod_matrix_power.f
src/fmmp_pkg.sv
src/fmmp_lane.sv
src/fmmp_engine.sv
src/fibonacci_mod_matrix_power.sv
tb/sv/fibonacci_mod_matrix_power_tb.sv
